### rtl/core/pq_eetf_pkg.sv
// shared types, constants and fixed-point helpers for the pq eetf tone mapper
package pq_eetf_pkg;

    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned FRAC        = 16;
    localparam int unsigned QW          = 24;   // internal signed q8.16
    localparam int unsigned OPW         = 25;   // multiplier operand width
    localparam int unsigned PW          = 2 * OPW;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned NUM_STAGES  = 23;

    localparam logic signed [PW-1:0] Q_MAX_W   = PW'(64'sd8388607);
    localparam logic signed [PW-1:0] Q_MIN_W   = -PW'(64'sd8388608);
    localparam logic signed [PW-1:0] SAMPLE_MAX_W =
        (PW'(64'sd1) <<< SAMPLE_BITS) - PW'(64'sd1);
    localparam logic signed [27:0]   ONE_Q28   = 28'sd65536;
    localparam logic signed [OPW-1:0] ONE_OP   = OPW'(64'sd65536);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SOURCE_PQ      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_PQ_SPAN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SOURCE_PQ_SPAN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_START         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ONE_MINUS_KNEE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TARGET_NORM    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LIFT         = 3'd6;

    // pipeline stage roles
    localparam int unsigned ST_NORM_MUL   = 0;
    localparam int unsigned ST_NORM_RND   = 1;
    localparam int unsigned ST_KNEE_SUB   = 2;
    localparam int unsigned ST_T_MUL      = 3;
    localparam int unsigned ST_T_RND      = 4;
    localparam int unsigned ST_T2_MUL     = 5;
    localparam int unsigned ST_T2_RND     = 6;
    localparam int unsigned ST_T3_MUL     = 7;
    localparam int unsigned ST_T3_RND     = 8;
    localparam int unsigned ST_BASIS      = 9;
    localparam int unsigned ST_BLEND_MUL  = 10;
    localparam int unsigned ST_BLEND_RND  = 11;
    localparam int unsigned ST_BLEND_SUM  = 12;
    localparam int unsigned ST_OM         = 13;
    localparam int unsigned ST_OM2_MUL    = 14;
    localparam int unsigned ST_OM2_RND    = 15;
    localparam int unsigned ST_P4_MUL     = 16;
    localparam int unsigned ST_P4_RND     = 17;
    localparam int unsigned ST_LIFT_MUL   = 18;
    localparam int unsigned ST_LIFT_RND   = 19;
    localparam int unsigned ST_LIFT_ADD   = 20;
    localparam int unsigned ST_SCALE_MUL  = 21;
    localparam int unsigned ST_OUT        = 22;

    typedef struct packed {
        logic signed [PW-1:0]  prod;
        logic signed [PW-1:0]  prod_b;
        logic signed [PW-1:0]  prod_c;
        logic signed [QW-1:0]  e1;
        logic signed [QW-1:0]  t;
        logic signed [QW-1:0]  t2;
        logic signed [QW-1:0]  t3;
        logic signed [QW-1:0]  h00;
        logic signed [QW-1:0]  h10;
        logic signed [QW-1:0]  h01;
        logic signed [QW-1:0]  e2;
        logic                  below_knee;
        logic [SAMPLE_BITS-1:0] pq;
    } eetf_stage_t;

    function automatic logic signed [PW-1:0] smul(
        input logic signed [OPW-1:0] a,
        input logic signed [OPW-1:0] b
    );
        logic signed [PW-1:0] p;
        p = a * b;
        return p;
    endfunction

    // round to nearest, ties up, dropping n fraction bits
    function automatic logic signed [PW-1:0] rnd_shift(
        input logic signed [PW-1:0] p,
        input int unsigned          n
    );
        logic signed [PW-1:0] s;
        s = p + (PW'(64'sd1) <<< (n - 1));
        return s >>> n;
    endfunction

    function automatic logic signed [QW-1:0] sat_q(input logic signed [PW-1:0] x);
        logic signed [QW-1:0] r;
        if (x > Q_MAX_W) begin
            r = Q_MAX_W[QW-1:0];
        end else if (x < Q_MIN_W) begin
            r = Q_MIN_W[QW-1:0];
        end else begin
            r = x[QW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [QW-1:0] rnd_sat(input logic signed [PW-1:0] p);
        return sat_q(rnd_shift(p, FRAC));
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clamp_sample(
        input logic signed [PW-1:0] y
    );
        logic [SAMPLE_BITS-1:0] r;
        if (y < PW'(64'sd0)) begin
            r = '0;
        end else if (y > SAMPLE_MAX_W) begin
            r = '1;
        end else begin
            r = y[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/hdr_pq_tone_map_eetf_core.sv
// bt.2408 eetf tone mapper for pq samples, pipelined top level
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+------------------------
//  in      | in_valid, in_ready, pq_in                 | one pq sample item
//  out     | out_valid, out_ready, pq_out              | one tone-mapped item
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// one item per clock sustained while out_ready holds; 23 register stages, whose depth
// is set by the chain of registered multiplies
// (normalize, t, t^2, t^3, blend, (1-e)^2, ^4, lift, scale).
// rst_n clears the stage valid bits and loads the register defaults.
// each stage holds while its successor is full and stalled, so bubbles close up
// and nothing is lost or repeated; cfg writes are always taken.
module hdr_pq_tone_map_eetf_core
    import pq_eetf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] pq_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] pq_out,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [SAMPLE_BITS-1:0] min_source_pq_reg;
    logic [SAMPLE_BITS-1:0] source_pq_span_reg;
    logic [23:0]            inv_source_pq_span_reg;
    logic signed [17:0]     knee_start_reg;
    logic [23:0]            inv_one_minus_knee_reg;
    logic signed [17:0]     max_target_norm_reg;
    logic signed [17:0]     black_lift_reg;

    eetf_stage_t stage_reg  [NUM_STAGES];
    eetf_stage_t stage_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES-1:0]  valid_next;
    logic [NUM_STAGES-1:0]  stage_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_source_pq_reg      <= '0;
            source_pq_span_reg     <= SAMPLE_BITS'(65535);
            inv_source_pq_span_reg <= 24'd65536;
            knee_start_reg         <= 18'sd65536;
            inv_one_minus_knee_reg <= 24'd65536;
            max_target_norm_reg    <= 18'sd65536;
            black_lift_reg         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_SOURCE_PQ:      min_source_pq_reg      <= cfg_data[SAMPLE_BITS-1:0];
                CFG_SOURCE_PQ_SPAN:     source_pq_span_reg     <= cfg_data[SAMPLE_BITS-1:0];
                CFG_INV_SOURCE_PQ_SPAN: inv_source_pq_span_reg <= cfg_data;
                CFG_KNEE_START:         knee_start_reg         <= $signed(cfg_data[17:0]);
                CFG_INV_ONE_MINUS_KNEE: inv_one_minus_knee_reg <= cfg_data;
                CFG_MAX_TARGET_NORM:    max_target_norm_reg    <= $signed(cfg_data[17:0]);
                CFG_BLACK_LIFT:         black_lift_reg         <= $signed(cfg_data[17:0]);
                default: ;
            endcase
        end
    end

    // operands widened to the multiplier width
    logic signed [OPW-1:0] ks_op;
    logic signed [OPW-1:0] omk_op;
    logic signed [OPW-1:0] inv_omk_op;
    logic signed [OPW-1:0] inv_span_op;
    logic signed [OPW-1:0] mtn_op;
    logic signed [OPW-1:0] lift_op;
    logic signed [OPW-1:0] span_op;
    logic signed [OPW-1:0] min_op;

    assign ks_op       = OPW'(knee_start_reg);
    assign omk_op      = ONE_OP - ks_op;
    assign inv_omk_op  = $signed(OPW'(inv_one_minus_knee_reg));
    assign inv_span_op = $signed(OPW'(inv_source_pq_span_reg));
    assign mtn_op      = OPW'(max_target_norm_reg);
    assign lift_op     = OPW'(black_lift_reg);
    assign span_op     = $signed(OPW'(source_pq_span_reg));
    assign min_op      = $signed(OPW'(min_source_pq_reg));

    function automatic eetf_stage_t stage_fn(
        input int unsigned k,
        input eetf_stage_t s
    );
        eetf_stage_t          n;
        logic signed [27:0]   t1x;
        logic signed [27:0]   t2x;
        logic signed [27:0]   t3x;
        logic signed [27:0]   sum;
        n   = s;
        t1x = 28'(s.t);
        t2x = 28'(s.t2);
        t3x = 28'(s.t3);
        sum = 28'(s.h00) + 28'(s.h10) + 28'(s.h01);
        case (k)
            ST_NORM_RND:  n.e1 = sat_q(rnd_shift(s.prod, SAMPLE_BITS));
            ST_KNEE_SUB:
            begin
                n.below_knee = (OPW'(s.e1) < ks_op);
                n.t          = sat_q(PW'(OPW'(s.e1) - ks_op));
            end
            ST_T_MUL:     n.prod = smul(OPW'(s.t), inv_omk_op);
            ST_T_RND:     n.t    = rnd_sat(s.prod);
            ST_T2_MUL:    n.prod = smul(OPW'(s.t), OPW'(s.t));
            ST_T2_RND:    n.t2   = rnd_sat(s.prod);
            ST_T3_MUL:    n.prod = smul(OPW'(s.t2), OPW'(s.t));
            ST_T3_RND:    n.t3   = rnd_sat(s.prod);
            ST_BASIS:
            begin
                n.h00 = sat_q(PW'(28'sd2 * t3x - 28'sd3 * t2x + ONE_Q28));
                n.h10 = sat_q(PW'(t3x - 28'sd2 * t2x + t1x));
                n.h01 = sat_q(PW'(28'sd3 * t2x - 28'sd2 * t3x));
            end
            ST_BLEND_MUL:
            begin
                n.prod   = smul(OPW'(s.h00), ks_op);
                n.prod_b = smul(OPW'(s.h10), omk_op);
                n.prod_c = smul(OPW'(s.h01), mtn_op);
            end
            ST_BLEND_RND:
            begin
                n.h00 = rnd_sat(s.prod);
                n.h10 = rnd_sat(s.prod_b);
                n.h01 = rnd_sat(s.prod_c);
            end
            ST_BLEND_SUM: n.e2 = s.below_knee ? s.e1 : sat_q(PW'(sum));
            ST_OM:        n.t  = sat_q(PW'(ONE_OP - OPW'(s.e2)));
            ST_OM2_MUL:   n.prod = smul(OPW'(s.t), OPW'(s.t));
            ST_OM2_RND:   n.t    = rnd_sat(s.prod);
            ST_P4_MUL:    n.prod = smul(OPW'(s.t), OPW'(s.t));
            ST_P4_RND:    n.t    = rnd_sat(s.prod);
            ST_LIFT_MUL:  n.prod = smul(OPW'(s.t), lift_op);
            ST_LIFT_RND:  n.t    = rnd_sat(s.prod);
            // e2 now carries e3
            ST_LIFT_ADD:  n.e2   = sat_q(PW'(OPW'(s.t) + OPW'(s.e2)));
            ST_SCALE_MUL: n.prod = smul(OPW'(s.e2), span_op);
            ST_OUT:       n.pq   = clamp_sample(rnd_shift(s.prod, FRAC) + PW'(min_op));
            default: ;
        endcase
        return n;
    endfunction

    // a stage can load when empty or when its successor moves
    always_comb
    begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    always_comb
    begin
        stage_next[ST_NORM_MUL]      = stage_reg[ST_NORM_MUL];
        stage_next[ST_NORM_MUL].prod = smul($signed(OPW'(pq_in)) - min_op, inv_span_op);
        valid_next[ST_NORM_MUL]      = in_valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            stage_next[i] = stage_fn(i, stage_reg[i-1]);
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (stage_ready[i] && valid_next[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign pq_out    = stage_reg[NUM_STAGES-1].pq;

    // an empty output slot means the whole chain can take an item
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output stage is empty");

    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_BLEND_SUM] && !stage_ready[ST_BLEND_SUM])
            |=> (valid_reg[ST_BLEND_SUM] && $stable(stage_reg[ST_BLEND_SUM])))
        else $error("stalled blend stage changed");

    // below the knee the sample passes the spline untouched
    a_below_knee_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_BLEND_SUM] && stage_reg[ST_BLEND_SUM].below_knee)
            |-> (stage_reg[ST_BLEND_SUM].e2 == stage_reg[ST_BLEND_SUM].e1))
        else $error("below-knee item was altered by the spline");

endmodule
